/* design/cft_pkg.sv */
// Shared types and constants for the CSV field tokenizer.
`timescale 1ns / 1ps

package cft_pkg;

  localparam logic [7:0] QuoteByte   = 8'h22;
  localparam logic [7:0] NewlineByte = 8'h0A;

  // Number of byte slots that the separator register holds.
  localparam int unsigned RegSlots = 4;

  localparam int unsigned CfgIndexBits = 1;
  localparam logic [CfgIndexBits-1:0] CfgSeparatorSet   = 1'b0;
  localparam logic [CfgIndexBits-1:0] CfgSeparatorCount = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       finish;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_field;
    logic       end_of_record;
    logic [7:0] column_index;
  } out_t;

endpackage

/* design/cft_sep_match.sv */
// Separator set match: tells whether a byte is one of the active separator bytes.
`timescale 1ns / 1ps

module cft_sep_match import cft_pkg::*; #(
  parameter int unsigned SEPARATOR_SLOTS = 4
) (
  input  logic [8*RegSlots-1:0] sep_set_i,
  input  logic [2:0]            sep_count_i,
  input  logic [7:0]            byte_i,
  output logic                  hit_o
);

  logic [SEPARATOR_SLOTS-1:0] slot_hit;

  for (genvar k = 0; k < SEPARATOR_SLOTS; k++) begin : g_slot
    logic [7:0] slot_byte;
    if (k < RegSlots) begin : g_reg
      assign slot_byte = sep_set_i[8*k +: 8];
    end else begin : g_zero
      // Slots beyond the register hold the byte zero.
      assign slot_byte = 8'h00;
    end
    assign slot_hit[k] = (32'(sep_count_i) > k) && (slot_byte == byte_i);
  end

  assign hit_o = |slot_hit;

endmodule

/* design/csv_field_tokenizer.sv */
// Top level of the CSV field tokenizer: input register, mode update, result register.
`timescale 1ns / 1ps

// Takes CSV text one byte per beat and gives at most one result beat per input
// beat: a field byte, a field end or a record end, with the column index. Input
// beats are taken at one per cycle for as long as results are drained; a result
// is offered on the output once its byte is accepted and its result is
// registered (the byte lands in the input register, its result in the result
// register after it). The mode and column update for one byte is combinational
// and sits between those registers, so that update sets the rate. Configuration
// writes are taken at any time and must only be issued while the block is idle.
module csv_field_tokenizer import cft_pkg::*; #(
  parameter int unsigned SEPARATOR_SLOTS = 4,
  parameter int unsigned COLUMN_BITS     = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_t                     in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_t                    out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [31:0]             cfg_data_i
);

  typedef enum logic [2:0] {
    ModeLineStart  = 3'd0,
    ModeFieldStart = 3'd1,
    ModePlain      = 3'd2,
    ModeQuoted     = 3'd3,
    ModeQuoteSeen  = 3'd4
  } mode_e;

  localparam logic [COLUMN_BITS-1:0] ColMax = '1;

  logic [8*RegSlots-1:0] sep_set_q;
  logic [2:0]            sep_count_q;

  logic                  in_valid_q;
  in_t                   in_q;
  logic                  out_valid_q;
  out_t                  out_q;
  mode_e                 mode_q, mode_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;

  logic                  sep_hit;
  logic                  produce;
  logic                  fire;
  out_t                  res;
  logic [COLUMN_BITS+7:0] col_ext;
  logic [7:0]            col_sat;

  cft_sep_match #(
    .SEPARATOR_SLOTS(SEPARATOR_SLOTS)
  ) u_sep_match (
    .sep_set_i  (sep_set_q),
    .sep_count_i(sep_count_q),
    .byte_i     (in_q.text_byte),
    .hit_o      (sep_hit)
  );

  assign col_ext = {8'h00, col_q};
  assign col_sat = (col_ext > (COLUMN_BITS+8)'(255)) ? 8'hFF : col_ext[7:0];

  // Mode and column update for the byte in the input register.
  always_comb begin
    logic       is_nl;
    logic       is_qt;
    logic [7:0] b;
    b       = in_q.text_byte;
    is_nl   = (b == NewlineByte);
    is_qt   = (b == QuoteByte);
    mode_d  = mode_q;
    col_d   = col_q;
    produce = 1'b0;
    res     = '{out_byte: 8'h00, has_byte: 1'b0, end_of_field: 1'b0,
                end_of_record: 1'b0, column_index: col_sat};
    if (in_q.finish) begin
      if (mode_q != ModeLineStart) begin
        produce           = 1'b1;
        res.end_of_field  = 1'b1;
        res.end_of_record = 1'b1;
        col_d             = '0;
        mode_d            = ModeLineStart;
      end
    end else begin
      unique case (mode_q)
        ModeLineStart, ModeFieldStart: begin
          priority if (is_nl) begin
            if (mode_q == ModeFieldStart) begin
              produce           = 1'b1;
              res.end_of_field  = 1'b1;
              res.end_of_record = 1'b1;
              col_d             = '0;
              mode_d            = ModeLineStart;
            end
          end else if (is_qt) begin
            mode_d = ModeQuoted;
          end else if (sep_hit) begin
            produce          = 1'b1;
            res.end_of_field = 1'b1;
            if (col_q != ColMax) col_d = col_q + 1'b1;
            mode_d           = ModeFieldStart;
          end else begin
            produce      = 1'b1;
            res.out_byte = b;
            res.has_byte = 1'b1;
            mode_d       = ModePlain;
          end
        end
        ModePlain: begin
          priority if (is_nl) begin
            produce           = 1'b1;
            res.end_of_field  = 1'b1;
            res.end_of_record = 1'b1;
            col_d             = '0;
            mode_d            = ModeLineStart;
          end else if (sep_hit) begin
            produce          = 1'b1;
            res.end_of_field = 1'b1;
            if (col_q != ColMax) col_d = col_q + 1'b1;
            mode_d           = ModeFieldStart;
          end else begin
            produce      = 1'b1;
            res.out_byte = b;
            res.has_byte = 1'b1;
          end
        end
        ModeQuoted: begin
          if (is_qt) begin
            mode_d = ModeQuoteSeen;
          end else begin
            produce      = 1'b1;
            res.out_byte = b;
            res.has_byte = 1'b1;
          end
        end
        ModeQuoteSeen: begin
          priority if (is_nl) begin
            produce           = 1'b1;
            res.end_of_field  = 1'b1;
            res.end_of_record = 1'b1;
            col_d             = '0;
            mode_d            = ModeLineStart;
          end else if (is_qt) begin
            // A doubled quote gives one quote and stays inside the quotes.
            produce      = 1'b1;
            res.out_byte = b;
            res.has_byte = 1'b1;
            mode_d       = ModeQuoted;
          end else if (sep_hit) begin
            produce          = 1'b1;
            res.end_of_field = 1'b1;
            if (col_q != ColMax) col_d = col_q + 1'b1;
            mode_d           = ModeFieldStart;
          end else begin
            produce      = 1'b1;
            res.out_byte = b;
            res.has_byte = 1'b1;
            mode_d       = ModePlain;
          end
        end
        default: begin
          mode_d = ModeLineStart;
          col_d  = '0;
        end
      endcase
    end
  end

  // A byte without a result moves on even while the result register stalls.
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i || !produce);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_set_q   <= (8*RegSlots)'(44);
      sep_count_q <= 3'd1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeLineStart;
      col_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgSeparatorSet:   sep_set_q   <= cfg_data_i[8*RegSlots-1:0];
          CfgSeparatorCount: sep_count_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        mode_q <= mode_d;
        col_q  <= col_d;
      end
      if (fire && produce) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (fire && produce) begin
      out_q <= res;
    end
  end

  a_byte_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.has_byte && out_q.end_of_field))
    else $error("result carries a byte and a field end together");

  a_record_is_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.end_of_record |-> out_q.end_of_field)
    else $error("record end without field end");

  a_empty_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.has_byte |-> out_q.out_byte == 8'h00)
    else $error("byte field not zero on a field end");

  a_record_clears_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && produce && res.end_of_record |=> col_q == '0 && mode_q == ModeLineStart)
    else $error("record end did not return to line start");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_q))
    else $error("held input beat lost");

endmodule
